/* hdl/dart_pkg.sv */
package dart_pkg;

  localparam int unsigned CYCLES_W = 12;
  localparam int unsigned ACCUM_W  = 32;
  localparam int unsigned PERIOD_W = 11;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_RESET = 2'd3;

  localparam logic [1:0] SEL_DIV  = 2'd0;
  localparam logic [1:0] SEL_TIMA = 2'd1;
  localparam logic [1:0] SEL_TMA  = 2'd2;
  localparam logic [1:0] SEL_TAC  = 2'd3;

  localparam logic [PERIOD_W-1:0] DIV_PERIOD = 11'd256;
  localparam int unsigned         TAC_ENABLE_BIT = 2;
  localparam logic [7:0]          TIMA_TOP = 8'hff;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CYCLES_W-1:0] tick_cycles;
    logic [1:0]          reg_select;
    logic [7:0]          write_data;
  } item_t;

  function automatic logic [PERIOD_W-1:0] rate_period(input logic [1:0] rate);
    logic [PERIOD_W-1:0] p;
    case (rate)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      2'd3:    p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

/* hdl/divider_and_reload_timer_top.sv */
// a word accepted into the input register passes to the output register once the output is free
// throughput: one word per cycle while out_stall is low; the add-compare-subtract of each accumulator sets the pace
// an input register and an output register separate the two channels
// rst (synchronous, active high) clears all timer registers, accumulators and valids
// a reset word clears the timer registers and accumulators and returns a result of zeros
module divider_and_reload_timer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [dart_pkg::CYCLES_W-1:0] tick_cycles,
  input  logic [1:0]                    reg_select,
  input  logic [7:0]                    write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    read_data,
  output logic                          timer_irq
);
  import dart_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  out_free;
  logic  s1_go;
  logic  accept;
  logic [7:0] read_data_next;
  logic       timer_irq_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= '{mode: mode, tick_cycles: tick_cycles,
                   reg_select: reg_select, write_data: write_data};
    end
  end

  dart_core u_core (
    .clk            (clk),
    .rst            (rst),
    .go             (s1_go),
    .item           (s1_item),
    .read_data_next (read_data_next),
    .timer_irq_next (timer_irq_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      read_data <= read_data_next;
      timer_irq <= timer_irq_next;
    end
  end

  a_irq_only_tick: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.mode != MODE_TICK) |=> !timer_irq)
    else $error("irq raised on a non-tick word");

  a_data_only_read: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.mode != MODE_READ) |=> (read_data == 8'd0))
    else $error("read data nonzero on a non-read word");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

/* hdl/dart_accum.sv */
module dart_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          tick,
  input  logic [dart_pkg::CYCLES_W-1:0] cycles,
  input  logic                          enable,
  input  logic [dart_pkg::PERIOD_W-1:0] period,
  output logic                          fire
);
  import dart_pkg::*;

  logic [ACCUM_W-1:0] accum;
  logic [ACCUM_W-1:0] accum_next;
  logic [ACCUM_W-1:0] sum;

  // sum wraps modulo the accumulator width
  assign sum  = accum + {{(ACCUM_W-CYCLES_W){1'b0}}, cycles};
  assign fire = tick && enable && (sum > {{(ACCUM_W-PERIOD_W){1'b0}}, period});

  always_comb begin
    accum_next = accum;
    if (tick) begin
      accum_next = fire ? (sum - {{(ACCUM_W-PERIOD_W){1'b0}}, period}) : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      accum <= '0;
    end else begin
      accum <= accum_next;
    end
  end

endmodule

/* hdl/dart_core.sv */
module dart_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  dart_pkg::item_t item,
  output logic [7:0]      read_data_next,
  output logic            timer_irq_next
);
  import dart_pkg::*;

  logic [7:0] divider_count;
  logic [7:0] timer_count;
  logic [7:0] reload_value;
  logic [7:0] timer_control;

  logic tick;
  logic clear;
  logic div_fire;
  logic tim_fire;
  logic reload;

  assign tick  = go && (item.mode == MODE_TICK);
  assign clear = go && (item.mode == MODE_RESET);

  dart_accum u_div_accum (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .tick   (tick),
    .cycles (item.tick_cycles),
    .enable (1'b1),
    .period (DIV_PERIOD),
    .fire   (div_fire)
  );

  dart_accum u_tim_accum (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .tick   (tick),
    .cycles (item.tick_cycles),
    .enable (timer_control[TAC_ENABLE_BIT]),
    .period (rate_period(timer_control[1:0])),
    .fire   (tim_fire)
  );

  assign reload         = tim_fire && (timer_count == TIMA_TOP);
  assign timer_irq_next = reload;

  always_comb begin
    read_data_next = 8'd0;
    if (item.mode == MODE_READ) begin
      case (item.reg_select)
        SEL_DIV:  read_data_next = divider_count;
        SEL_TIMA: read_data_next = timer_count;
        SEL_TMA:  read_data_next = reload_value;
        SEL_TAC:  read_data_next = timer_control;
        default:  read_data_next = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      divider_count <= 8'd0;
      timer_count   <= 8'd0;
      reload_value  <= 8'd0;
      timer_control <= 8'd0;
    end else if (tick) begin
      if (div_fire) begin
        divider_count <= divider_count + 8'd1;
      end
      if (reload) begin
        timer_count <= reload_value;
      end else if (tim_fire) begin
        timer_count <= timer_count + 8'd1;
      end
    end else if (go && (item.mode == MODE_WRITE)) begin
      case (item.reg_select)
        SEL_DIV:  divider_count <= item.write_data;
        SEL_TIMA: timer_count   <= item.write_data;
        SEL_TMA:  reload_value  <= item.write_data;
        SEL_TAC:  timer_control <= item.write_data;
        default:  divider_count <= divider_count;
      endcase
    end
  end

  a_reload_value: assert property (@(posedge clk) disable iff (rst)
    reload |=> (timer_count == $past(reload_value)))
    else $error("reload did not load TIMA from TMA");

  a_reset_item: assert property (@(posedge clk) disable iff (rst)
    clear |=> (divider_count == 8'd0 && timer_count == 8'd0 &&
               reload_value == 8'd0 && timer_control == 8'd0))
    else $error("reset word left registers set");

endmodule
